/* src/indexed_list_engine_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the indexed list engine
// Shorthand for clocked assertions that are disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_ENGINE_CORE_MACROS_SVH
`define INDEXED_LIST_ENGINE_CORE_MACROS_SVH

// Same-cycle implication.
`define ILE_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/ile_pkg.sv */
// ----------------------------------------------------------------------------
// Indexed list engine package
// Request and status codes, field widths and the result record.
// ----------------------------------------------------------------------------
package ile_pkg;

   localparam int KIND_W  = 2;
   localparam int POS_W   = 9;
   localparam int VALUE_W = 32;
   localparam int FPOS_W  = 8;
   localparam int LEN_W   = 9;

   typedef enum logic [KIND_W-1:0] {
      REQ_INSERT = 2'd0,
      REQ_DELETE = 2'd1,
      REQ_FIND   = 2'd2,
      REQ_NONE   = 2'd3
   } req_kind_type;

   typedef enum logic [KIND_W-1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_FULL   = 2'd2,
      STATUS_RSVD   = 2'd3
   } status_type;

   typedef struct packed {
      status_type          status;
      logic                found;
      logic [FPOS_W-1:0]   found_position;
      logic [LEN_W-1:0]    list_length;
   } result_type;

endpackage

/* src/ile_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ile_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/ile_ctrl.sv */
// ----------------------------------------------------------------------------
// Indexed list engine sequencer
// Walks the entry memory one entry per cycle to shift, close gaps or search.
// ----------------------------------------------------------------------------
module ile_ctrl #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ile_pkg::req_kind_type         req_kind,
   input  logic [ile_pkg::POS_W-1:0]     req_pos,
   input  logic [DATA_WIDTH-1:0]         req_val,
   output logic                          res_valid,
   input  logic                          res_ack,
   output ile_pkg::result_type           result,
   output logic                          wr_en,
   output logic [$clog2(DEPTH)-1:0]      wr_addr,
   output logic [DATA_WIDTH-1:0]         wr_data,
   output logic                          rd_en,
   output logic [$clog2(DEPTH)-1:0]      rd_addr,
   input  logic [DATA_WIDTH-1:0]         rd_data
);

   import ile_pkg::*;

   localparam int AW    = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE,
      S_LAST,
      S_PUT,
      S_RESP
   } state_type;

   state_type              state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   req_kind_type           op_ff, op_in;
   logic [AW-1:0]          pos_ff, pos_in;
   logic [DATA_WIDTH-1:0]  val_ff, val_in;
   logic [AW-1:0]          src_ff, src_in;
   logic [AW-1:0]          end_ff, end_in;
   logic                   pend_ff, pend_in;
   logic [AW-1:0]          pend_addr_ff, pend_addr_in;
   status_type             status_ff, status_in;
   logic                   found_ff, found_in;
   logic [FPOS_W-1:0]      fpos_ff, fpos_in;

   logic [CMP_W-1:0]       pos_c;
   logic [CMP_W-1:0]       cnt_c;
   logic [CMP_W-1:0]       cnt_m1_c;
   logic [CMP_W-1:0]       pend_c;
   logic [CMP_W-1:0]       len_c;
   logic                   match;

   always_comb begin
      pos_c    = CMP_W'(req_pos);
      cnt_c    = CMP_W'(count_ff);
      cnt_m1_c = cnt_c - CMP_W'(1);
      pend_c   = CMP_W'(pend_addr_ff);
      len_c    = CMP_W'(count_ff);
      match    = pend_ff && (rd_data == val_ff);

      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      src_in       = src_ff;
      end_in       = end_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      status_in    = status_ff;
      found_in     = found_ff;
      fpos_in      = fpos_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               op_in     = req_kind;
               pos_in    = pos_c[AW-1:0];
               val_in    = req_val;
               status_in = STATUS_OK;
               found_in  = 1'b0;
               fpos_in   = '0;
               case (req_kind)
                  REQ_INSERT: begin
                     if (pos_c > cnt_c) begin
                        status_in = STATUS_BADPOS;
                        state_in  = S_RESP;
                     end else if (cnt_c >= CMP_W'(DEPTH)) begin
                        status_in = STATUS_FULL;
                        state_in  = S_RESP;
                     end else if (pos_c == cnt_c) begin
                        state_in = S_PUT;
                     end else begin
                        src_in   = cnt_m1_c[AW-1:0];
                        end_in   = pos_c[AW-1:0];
                        state_in = S_MOVE;
                     end
                  end
                  REQ_DELETE: begin
                     if (pos_c >= cnt_c) begin
                        status_in = STATUS_BADPOS;
                        state_in  = S_RESP;
                     end else if (pos_c == cnt_m1_c) begin
                        state_in = S_LAST;
                     end else begin
                        src_in   = pos_c[AW-1:0] + AW'(1);
                        end_in   = cnt_m1_c[AW-1:0];
                        state_in = S_MOVE;
                     end
                  end
                  REQ_FIND: begin
                     if (count_ff == '0) begin
                        state_in = S_RESP;
                     end else begin
                        src_in   = '0;
                        end_in   = cnt_m1_c[AW-1:0];
                        state_in = S_MOVE;
                     end
                  end
                  default: begin
                     status_in = STATUS_BADPOS;
                     state_in  = S_RESP;
                  end
               endcase
            end
         end
         S_MOVE: begin
            if (op_ff == REQ_FIND && match) begin
               found_in = 1'b1;
               fpos_in  = pend_c[FPOS_W-1:0];
               state_in = S_RESP;
            end else begin
               pend_in = 1'b1;
               case (op_ff)
                  REQ_INSERT: pend_addr_in = src_ff + AW'(1);
                  REQ_DELETE: pend_addr_in = src_ff - AW'(1);
                  default:    pend_addr_in = src_ff;
               endcase
               if (src_ff == end_ff) begin
                  state_in = S_LAST;
               end else if (op_ff == REQ_INSERT) begin
                  src_in = src_ff - AW'(1);
               end else begin
                  src_in = src_ff + AW'(1);
               end
            end
         end
         S_LAST: begin
            case (op_ff)
               REQ_INSERT: state_in = S_PUT;
               REQ_DELETE: begin
                  count_in = count_ff - CNT_W'(1);
                  state_in = S_RESP;
               end
               default: begin
                  if (match) begin
                     found_in = 1'b1;
                     fpos_in  = pend_c[FPOS_W-1:0];
                  end
                  state_in = S_RESP;
               end
            endcase
         end
         S_PUT: begin
            count_in = count_ff + CNT_W'(1);
            state_in = S_RESP;
         end
         S_RESP: begin
            if (res_ack) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
      op_ff        <= op_in;
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      src_ff       <= src_in;
      end_ff       <= end_in;
      pend_addr_ff <= pend_addr_in;
      status_ff    <= status_in;
      found_ff     <= found_in;
      fpos_ff      <= fpos_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP);

   assign result.status         = status_ff;
   assign result.found          = found_ff;
   assign result.found_position = fpos_ff;
   assign result.list_length    = len_c[LEN_W-1:0];

   assign rd_en   = (state_ff == S_MOVE);
   assign rd_addr = src_ff;
   assign wr_en   = (state_ff == S_PUT) || (pend_ff && op_ff != REQ_FIND);
   assign wr_addr = (state_ff == S_PUT) ? pos_ff : pend_addr_ff;
   assign wr_data = (state_ff == S_PUT) ? val_ff : rd_data;

endmodule

/* src/indexed_list_engine_core.sv */
// ----------------------------------------------------------------------------
// Indexed list engine
// Ordered list of data words with positional insert, delete and value search.
//
// Requests arrive on the req_ stream; each accepted beat yields exactly one
// rsp_ beat. req_tuser carries the request kind, req_tdata the position and
// the data word. rsp_tuser carries the status, rsp_tdata the search result
// and the list length after the request.
// One request is worked on at a time. A rejected request goes straight to
// its response. Insert shifts the entries from the position upward by one
// and then writes the new word, or only writes it when it appends at the end;
// delete shifts the entries above the position down by one. Find reads the
// entries from position 0 and stops at the first match. The walk over the
// entry memory reads one entry per cycle and, for insert and delete, writes one per cycle.
// Reset empties the list; the memory contents are not cleared.
// A finished response waits in the output register while rsp_tready is low;
// the engine can accept the next request in the meantime, and holds a
// further response until that register frees up.
// ----------------------------------------------------------------------------
`include "indexed_list_engine_core_macros.svh"

module indexed_list_engine_core #(
   parameter int DEPTH      = 256,
   parameter int DATA_WIDTH = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // [8:0] position, [40:9] item_value, [47:41] zero
   input  logic [47:0]              req_tdata,
   // [1:0] req_type
   input  logic [ile_pkg::KIND_W-1:0] req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // [0] found, [8:1] found_position, [17:9] list_length, [23:18] zero
   output logic [23:0]              rsp_tdata,
   // [1:0] status
   output logic [ile_pkg::KIND_W-1:0] rsp_tuser
);

   import ile_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic                   wr_en;
   logic [AW-1:0]          wr_addr;
   logic [DATA_WIDTH-1:0]  wr_data;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic [DATA_WIDTH-1:0]  rd_data;

   logic                   res_valid;
   logic                   res_ack;
   result_type             result;

   logic [63:0]            value_ext;
   logic [DATA_WIDTH-1:0]  req_val;

   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             rsp_ff, rsp_in;
   logic                   rsp_error;

   assign value_ext = 64'(req_tdata[POS_W +: VALUE_W]);
   assign req_val   = value_ext[DATA_WIDTH-1:0];

   ile_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_kind_type'(req_tuser)),
      .req_pos   (req_tdata[POS_W-1:0]),
      .req_val   (req_val),
      .res_valid (res_valid),
      .res_ack   (res_ack),
      .result    (result),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   ile_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign res_ack = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ack) begin
         rsp_valid_in = 1'b1;
         rsp_in       = result;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {6'b0, rsp_ff.list_length, rsp_ff.found_position, rsp_ff.found};

   assign rsp_error = rsp_valid_ff && (rsp_ff.status != STATUS_OK);

   `ILE_ASSERT_NEXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready, "request overlap")
   `ILE_ASSERT_IMPLIES(a_found_is_ok, rsp_error, !rsp_ff.found, "found with error status")
   `ILE_ASSERT_IMPLIES(a_error_clean, rsp_error, rsp_tdata[8:0] == '0, "search data on error")

endmodule
